[hw/rtl/tpsg_pkg.sv]
// tpsg_pkg: shared types, constants and the quarter-wave sine table builder
// for the three-phase sine generator. No dependencies.
package tpsg_pkg;

  localparam int SINE_TABLE_BITS  = 10;
  localparam int SINE_SAMPLE_BITS = 16;

  localparam int QUARTER_LEN = 1 << SINE_TABLE_BITS;
  localparam int ROM_AW      = SINE_TABLE_BITS + 1;     // addresses 0..QUARTER_LEN
  localparam int ROM_DW      = SINE_SAMPLE_BITS + 1;    // magnitude up to 2^SAMPLE_BITS
  localparam int SINE_W      = SINE_SAMPLE_BITS + 2;    // signed sine sample

  localparam int STEP_W = 40;
  localparam logic [STEP_W-1:0] STEP_RESET = 40'd28147497671;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  localparam logic [31:0] SHIFT_120 = 32'd1431655765;
  localparam logic [31:0] SHIFT_240 = 32'd2863311531;

  localparam int PHASE_IDX_W = 2;
  localparam logic [PHASE_IDX_W-1:0] PHASE_A_IDX = 2'd0;
  localparam logic [PHASE_IDX_W-1:0] PHASE_B_IDX = 2'd1;
  localparam logic [PHASE_IDX_W-1:0] LAST_PHASE  = 2'd2;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INC_LO,
    ST_INC_HI,
    ST_ADVANCE,
    ST_LOOKUP,
    ST_MULT,
    ST_ROUND,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MUL_INC_LO,
    MUL_INC_HI,
    MUL_SINE
  } mul_sel_t;

  typedef struct packed {
    logic                   idle;
    mul_sel_t               mul_sel;
    logic                   save_lo;
    logic                   advance;
    logic [PHASE_IDX_W-1:0] lookup_idx;
    logic [PHASE_IDX_W-1:0] res_idx;
    logic                   store_res;
    logic                   out_load;
  } ctrl_t;

  typedef logic [ROM_DW-1:0] sine_rom_t [0:QUARTER_LEN];

  // restoring long division, only evaluated while the table is built
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned den);
    logic [63:0] n;
    logic [63:0] q;
    logic [63:0] r;
    n = num;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Q30 Taylor series, terms to x^17, each step truncated; rounded half up
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t         rom;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   mag;
    longint unsigned   v;
    longint            sum;
    for (int i = 0; i <= QUARTER_LEN; i++) begin
      x   = (HALF_PI_Q30 * longint'(i)) >> SINE_TABLE_BITS;
      x2  = (x * x) >> 30;
      mag = x;
      sum = longint'(x);
      for (int k = 1; k <= 8; k++) begin
        mag = div_u64((mag * x2) >> 30, longint'((2 * k) * (2 * k + 1)));
        if (k % 2 == 1) begin
          sum = sum - longint'(mag);
        end else begin
          sum = sum + longint'(mag);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = ((longint'(sum) << SINE_SAMPLE_BITS) + (64'd1 << 29)) >> 30;
      if (v > (64'd1 << SINE_SAMPLE_BITS)) begin
        v = 64'd1 << SINE_SAMPLE_BITS;
      end
      rom[i] = ROM_DW'(v);
    end
    return rom;
  endfunction

  function automatic logic [31:0] phase_shift(input logic [PHASE_IDX_W-1:0] idx);
    logic [31:0] s;
    unique case (idx)
      PHASE_A_IDX: s = 32'd0;
      PHASE_B_IDX: s = SHIFT_120;
      default:     s = SHIFT_240;
    endcase
    return s;
  endfunction

endpackage

[hw/rtl/three_phase_sine_generator.sv]
// three_phase_sine_generator: DDS top level with phase accumulator, operand
// selection, rounding/saturation and output register.
// Depends on tpsg_pkg, tpsg_ctrl, tpsg_mul, tpsg_sine_rom.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  cfg     | cfg_valid/cfg_ready  | phase_step_per_hertz (40b, turns/Hz * 2^64)
//  in      | in_valid/in_stall    | action, amplitude, frequency, dc_offset
//  out     | out_valid/out_stall  | phase_a, phase_b, phase_c (Q16.16, saturated)
//
// A sample request runs ST_INC_LO, ST_INC_HI, ST_ADVANCE, ST_LOOKUP, then
// ST_MULT/ST_ROUND per phase; ST_DONE loads the output register. No new
// request is taken before ST_IDLE. The order is set by the one shared
// multiplier (two products for the phase increment, three for the sines)
// and the registered table read. A phase-reset request clears the phase
// and produces no output. rst (synchronous) clears the phase, the step
// register to default and all control; a stalled output holds, as does ST_DONE.
module three_phase_sine_generator (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tpsg_pkg::STEP_W-1:0]         phase_step_per_hertz,
  // sample requests
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                action,
  input  logic signed [31:0]                  amplitude,
  input  logic [31:0]                         frequency,
  input  logic signed [31:0]                  dc_offset,
  // results
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [31:0]                  phase_a,
  output logic signed [31:0]                  phase_b,
  output logic signed [31:0]                  phase_c
);

  tpsg_pkg::ctrl_t ctrl;

  logic [tpsg_pkg::STEP_W-1:0] step;
  logic signed [31:0]          amp_q;
  logic [31:0]                 freq_q;
  logic signed [31:0]          off_q;
  logic [31:0]                 phase_acc;
  logic [31:0]                 inc_lo;       // high word of freq * step[31:0]
  logic                        sign_q;       // sign of the sample being read
  logic [31:0]                 res_q [3];

  logic                                 in_take;
  logic                                 out_free;
  logic signed [tpsg_pkg::MUL_W-1:0]    mul_a;
  logic signed [tpsg_pkg::MUL_W-1:0]    mul_b;
  logic signed [tpsg_pkg::PROD_W-1:0]   prod;
  logic [31:0]                          look_phase;
  logic [tpsg_pkg::SINE_TABLE_BITS-1:0] look_idx;
  logic [tpsg_pkg::ROM_AW-1:0]          rom_addr;
  logic [tpsg_pkg::ROM_DW-1:0]          rom_data;
  logic signed [tpsg_pkg::SINE_W-1:0]   sine_val;
  logic signed [tpsg_pkg::PROD_W-1:0]   rounded;
  logic signed [tpsg_pkg::PROD_W-1:0]   total;
  logic                                 fits;
  logic [31:0]                          sat;

  localparam logic signed [tpsg_pkg::PROD_W-1:0] ROUND_HALF =
    tpsg_pkg::PROD_W'(1) << (tpsg_pkg::SINE_SAMPLE_BITS - 1);

  assign cfg_ready = 1'b1;
  assign in_stall  = !ctrl.idle;
  assign in_take   = in_valid && ctrl.idle;
  assign out_free  = !out_valid || !out_stall;

  tpsg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // step register
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= tpsg_pkg::STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      step <= phase_step_per_hertz;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      amp_q  <= amplitude;
      freq_q <= frequency;
      off_q  <= dc_offset;
    end
  end

  // phase accumulator: increment = bits 63:32 of freq * step, split at bit 32
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (in_take && action) begin
      phase_acc <= '0;
    end else if (ctrl.advance) begin
      phase_acc <= phase_acc + prod[31:0] + inc_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.save_lo) begin
      inc_lo <= prod[63:32];
    end
  end

  // shared multiplier operands
  always_comb begin
    unique case (ctrl.mul_sel)
      tpsg_pkg::MUL_INC_LO: begin
        mul_a = $signed({1'b0, freq_q});
        mul_b = $signed({1'b0, step[31:0]});
      end
      tpsg_pkg::MUL_INC_HI: begin
        mul_a = $signed({1'b0, freq_q});
        mul_b = $signed(tpsg_pkg::MUL_W'(step[tpsg_pkg::STEP_W-1:32]));
      end
      default: begin
        mul_a = tpsg_pkg::MUL_W'(amp_q);
        mul_b = tpsg_pkg::MUL_W'(sine_val);
      end
    endcase
  end

  tpsg_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // table lookup: quadrant from the top two bits, odd quadrants mirrored
  assign look_phase = phase_acc - tpsg_pkg::phase_shift(ctrl.lookup_idx);
  assign look_idx   = look_phase[29 -: tpsg_pkg::SINE_TABLE_BITS];
  assign rom_addr   = look_phase[30]
                    ? tpsg_pkg::ROM_AW'(tpsg_pkg::QUARTER_LEN) - {1'b0, look_idx}
                    : {1'b0, look_idx};

  tpsg_sine_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  always_ff @(posedge clk) begin
    sign_q <= look_phase[31];
  end

  assign sine_val = sign_q ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});

  // round half up (floor), add offset, saturate to 32 bits
  assign rounded = (prod + ROUND_HALF) >>> tpsg_pkg::SINE_SAMPLE_BITS;
  assign total   = rounded + tpsg_pkg::PROD_W'(off_q);
  assign fits    = (total[tpsg_pkg::PROD_W-1:31] == '0)
                || (total[tpsg_pkg::PROD_W-1:31] == '1);
  assign sat     = fits ? total[31:0]
                 : (total[tpsg_pkg::PROD_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

  always_ff @(posedge clk) begin
    if (ctrl.store_res) begin
      res_q[ctrl.res_idx] <= sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      phase_a <= res_q[0];
      phase_b <= res_q[1];
      phase_c <= res_q[2];
    end
  end

`ifndef SYNTHESIS
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.out_load))
    else $error("output became valid without a finished sample");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending output");

  a_reset_request: assert property (@(posedge clk) disable iff (rst)
    (in_take && action) |=> (phase_acc == 32'd0))
    else $error("phase reset request did not clear the accumulator");

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(ctrl.advance) && !$past(in_take && action))
      |-> $stable(phase_acc))
    else $error("phase accumulator moved outside an advance step");
`endif

endmodule

[hw/rtl/tpsg_sine_rom.sv]
// tpsg_sine_rom: quarter-wave sine table with registered read.
// Depends on tpsg_pkg (table size and contents).
module tpsg_sine_rom (
  input  logic                        clk,
  input  logic [tpsg_pkg::ROM_AW-1:0] addr,
  output logic [tpsg_pkg::ROM_DW-1:0] data
);

  localparam tpsg_pkg::sine_rom_t ROM = tpsg_pkg::build_sine_rom();

  always_ff @(posedge clk) begin
    data <= ROM[addr];
  end

endmodule

[hw/rtl/tpsg_mul.sv]
// tpsg_mul: shared signed 33x33 multiplier with registered product.
// Depends on tpsg_pkg (operand widths).
module tpsg_mul (
  input  logic                               clk,
  input  logic signed [tpsg_pkg::MUL_W-1:0]  a,
  input  logic signed [tpsg_pkg::MUL_W-1:0]  b,
  output logic signed [tpsg_pkg::PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

[hw/rtl/tpsg_ctrl.sv]
// tpsg_ctrl: sequencer that steps the shared multiplier through the
// phase increment and the three sine products. Depends on tpsg_pkg.
module tpsg_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            action,
  input  logic            out_free,
  output tpsg_pkg::ctrl_t ctrl
);

  tpsg_pkg::state_t state;
  tpsg_pkg::state_t state_next;
  logic [tpsg_pkg::PHASE_IDX_W-1:0] idx;
  logic [tpsg_pkg::PHASE_IDX_W-1:0] idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpsg_pkg::ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    idx_next   = idx;
    unique case (state)
      tpsg_pkg::ST_IDLE: begin
        if (in_valid && !action) begin
          state_next = tpsg_pkg::ST_INC_LO;
        end
      end
      tpsg_pkg::ST_INC_LO:  state_next = tpsg_pkg::ST_INC_HI;
      tpsg_pkg::ST_INC_HI:  state_next = tpsg_pkg::ST_ADVANCE;
      tpsg_pkg::ST_ADVANCE: begin
        state_next = tpsg_pkg::ST_LOOKUP;
        idx_next   = '0;
      end
      tpsg_pkg::ST_LOOKUP:  state_next = tpsg_pkg::ST_MULT;
      tpsg_pkg::ST_MULT:    state_next = tpsg_pkg::ST_ROUND;
      tpsg_pkg::ST_ROUND: begin
        idx_next = idx + 1'b1;
        if (idx == tpsg_pkg::LAST_PHASE) begin
          state_next = tpsg_pkg::ST_DONE;
        end else begin
          state_next = tpsg_pkg::ST_MULT;
        end
      end
      tpsg_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = tpsg_pkg::ST_IDLE;
        end
      end
      default: state_next = tpsg_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl            = '0;
    ctrl.mul_sel    = tpsg_pkg::MUL_SINE;
    ctrl.lookup_idx = idx;
    ctrl.res_idx    = idx;
    unique case (state)
      tpsg_pkg::ST_IDLE:    ctrl.idle = 1'b1;
      tpsg_pkg::ST_INC_LO:  ctrl.mul_sel = tpsg_pkg::MUL_INC_LO;
      tpsg_pkg::ST_INC_HI: begin
        ctrl.mul_sel = tpsg_pkg::MUL_INC_HI;
        ctrl.save_lo = 1'b1;
      end
      tpsg_pkg::ST_ADVANCE: ctrl.advance = 1'b1;
      tpsg_pkg::ST_LOOKUP:  ctrl.lookup_idx = '0;
      tpsg_pkg::ST_MULT:    ctrl.mul_sel = tpsg_pkg::MUL_SINE;
      tpsg_pkg::ST_ROUND: begin
        // fetch the next phase's sample while this one is rounded
        ctrl.store_res  = 1'b1;
        ctrl.lookup_idx = idx + 1'b1;
      end
      tpsg_pkg::ST_DONE:    ctrl.out_load = out_free;
      default:              ctrl.idle = 1'b0;
    endcase
  end

endmodule
